// ===== rtl/dsfa_pkg.sv =====
package dsfa_pkg;

    // default ring capacity
    localparam int MAX_SEATS_DEF = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEAT_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTION_LIMIT = 1'd1;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [5:0]  SEAT_COUNT_RST    = 6'd5;
    localparam logic [15:0] PORTION_LIMIT_RST = 16'hFFFF;

    // seat states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_THINK  = 2'd0;
    localparam logic [ST_W-1:0] ST_HUNGRY = 2'd1;
    localparam logic [ST_W-1:0] ST_EAT    = 2'd2;

    // input modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // result kinds
    localparam logic [1:0] EV_GRANT  = 2'd0;
    localparam logic [1:0] EV_WAIT   = 2'd1;
    localparam logic [1:0] EV_REFUSE = 2'd2;
    localparam logic [1:0] EV_ACK    = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [4:0] seat;
    } req_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [4:0] target_seat;
        logic       last;
    } rsp_t;

endpackage

// ===== rtl/dsfa_ram.sv =====
module dsfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/dining_seat_fork_arbiter.sv =====
// Ring arbiter for seats sharing resources with their two neighbors.
// Channels: req (mode, seat) in, rsp (event_kind, target_seat, last) out,
// both valid/ready; cfg writes seat_count (index 0) or portion_limit
// (index 1) and is always ready.
// One item is worked at a time; req_ready is high only while the block
// is idle. Seat states live in a one-write, one-read RAM, and every
// neighbor test reads three entries through that single read port, one
// per cycle, so the work per item is:
//   seat outside the ring: no seat RAM access, straight to the result
//   request: state read, then, if thinking and within budget, one neighbor test
//   release: a test of the left, then of the right neighbor; two results when both seats are granted
// Results sit in an output register; a stalled receiver holds the block
// in its emit step until the register is free for each result, and the
// next item is accepted as soon as the last result of the item is loaded.
// Reset clears all seats to thinking (per-entry valid bits, no sweep),
// the portion count to zero and the registers to 5 seats and 65535
// portions, and empties the output register.
module dining_seat_fork_arbiter #(
    parameter int MAX_SEATS = dsfa_pkg::MAX_SEATS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  dsfa_pkg::req_t                     req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output dsfa_pkg::rsp_t                     rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dsfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import dsfa_pkg::*;

    localparam int SW  = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
    localparam int NW  = $clog2(MAX_SEATS + 1);
    localparam int CW  = (NW > 6) ? NW : 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_CHK,
        S_T_X,
        S_T_L,
        S_T_R,
        S_T_D,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [5:0]       seat_count_reg;
    logic [15:0]      portion_limit_reg;
    logic [15:0]      portions_used_reg;
    logic             mode_reg;
    logic             phase_reg;
    logic             gl_reg;
    logic             h_reg;
    logic             lok_reg;
    logic [4:0]       seat_reg;
    logic [SW-1:0]    seat_idx_reg;
    logic [SW-1:0]    tgt_reg;
    logic [SW-1:0]    left_reg;
    logic [SW-1:0]    right_reg;
    rsp_t             pend_reg [2];
    logic             pend_cnt_reg;
    logic             pend_idx_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;
    logic [MAX_SEATS-1:0] vld_reg;
    logic             rd_vld_reg;

    logic [CW-1:0]    sc_ext;
    logic [CW-1:0]    ring_n;
    logic [SW-1:0]    nm1;
    logic [SW-1:0]    seat_idx_in;
    logic             in_ring;
    logic             req_fire;
    logic [SW-1:0]    nb_x;
    logic [SW-1:0]    nb_dec;
    logic [SW-1:0]    nb_inc;
    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [ST_W-1:0]  ram_wdata;
    logic             ram_re;
    logic [SW-1:0]    ram_raddr;
    logic [ST_W-1:0]  ram_q;
    logic [ST_W-1:0]  st_rd;
    logic             budget_ok;
    logic             grant;
    logic             emit_fire;

    // effective ring size, clamped to 2..MAX_SEATS
    always_comb
    begin
        sc_ext = CW'(seat_count_reg);
        if (sc_ext < CW'(2))
        begin
            ring_n = CW'(2);
        end
        else if (sc_ext > CW'(MAX_SEATS))
        begin
            ring_n = CW'(MAX_SEATS);
        end
        else
        begin
            ring_n = sc_ext;
        end
    end

    assign nm1         = SW'(ring_n - CW'(1));
    assign seat_idx_in = SW'(req_data.seat);
    assign in_ring     = (CW'(req_data.seat) < ring_n);
    assign req_ready   = (state_reg == S_IDLE);
    assign req_fire    = req_valid && req_ready;
    assign cfg_ready   = 1'b1;

    // shared ring neighbor unit
    assign nb_x   = (state_reg == S_IDLE) ? seat_idx_in : tgt_reg;
    assign nb_dec = (nb_x == '0) ? nm1 : nb_x - SW'(1);
    assign nb_inc = (nb_x == nm1) ? '0 : nb_x + SW'(1);

    // entries never written read as thinking
    assign st_rd     = rd_vld_reg ? ram_q : ST_THINK;
    assign budget_ok = (portions_used_reg < portion_limit_reg);
    assign grant     = h_reg && lok_reg && (st_rd != ST_EAT);
    assign emit_fire = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp_ready);

    // seat state memory access per step
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tgt_reg;
        ram_wdata = ST_EAT;
        ram_re    = 1'b0;
        ram_raddr = tgt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && in_ring)
                begin
                    if (req_data.mode == MODE_REQUEST)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = seat_idx_in;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = seat_idx_in;
                        ram_wdata = ST_THINK;
                    end
                end
            end
            S_REQ_CHK:
            begin
                if (st_rd == ST_THINK && budget_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = seat_idx_reg;
                    ram_wdata = ST_HUNGRY;
                end
            end
            S_T_X:
            begin
                ram_re    = 1'b1;
                ram_raddr = tgt_reg;
            end
            S_T_L:
            begin
                ram_re    = 1'b1;
                ram_raddr = nb_dec;
            end
            S_T_R:
            begin
                ram_re    = 1'b1;
                ram_raddr = nb_inc;
            end
            S_T_D:
            begin
                ram_we    = grant;
                ram_waddr = tgt_reg;
                ram_wdata = ST_EAT;
            end
            S_EMIT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    dsfa_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_SEATS)
    ) u_seat_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // written-entry tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[ram_raddr];
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seat_count_reg    <= SEAT_COUNT_RST;
            portion_limit_reg <= PORTION_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEAT_COUNT:    seat_count_reg    <= cfg_data[5:0];
                CFG_PORTION_LIMIT: portion_limit_reg <= cfg_data;
                default:           seat_count_reg    <= seat_count_reg;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            portions_used_reg <= '0;
            rsp_valid_reg     <= 1'b0;
            pend_cnt_reg      <= 1'b0;
            pend_idx_reg      <= 1'b0;
            mode_reg          <= MODE_REQUEST;
            phase_reg         <= 1'b0;
            gl_reg            <= 1'b0;
            h_reg             <= 1'b0;
            lok_reg           <= 1'b0;
        end
        else
        begin
            // output register drains on transfer
            if (emit_fire)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_data_reg  <= pend_reg[pend_idx_reg];
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        mode_reg     <= req_data.mode;
                        seat_reg     <= req_data.seat;
                        seat_idx_reg <= seat_idx_in;
                        left_reg     <= nb_dec;
                        right_reg    <= nb_inc;
                        tgt_reg      <= nb_dec;
                        phase_reg    <= 1'b0;
                        pend_cnt_reg <= 1'b0;
                        pend_idx_reg <= 1'b0;
                        if (!in_ring)
                        begin
                            pend_reg[0] <= '{
                                event_kind:  (req_data.mode == MODE_RELEASE) ? EV_ACK
                                                                             : EV_REFUSE,
                                target_seat: req_data.seat,
                                last:        1'b1
                            };
                            state_reg <= S_EMIT;
                        end
                        else if (req_data.mode == MODE_REQUEST)
                        begin
                            state_reg <= S_REQ_CHK;
                        end
                        else
                        begin
                            state_reg <= S_T_X;
                        end
                    end
                end
                S_REQ_CHK:
                begin
                    pend_reg[0].target_seat <= seat_reg;
                    pend_reg[0].last        <= 1'b1;
                    tgt_reg                 <= seat_idx_reg;
                    priority if (st_rd == ST_EAT)
                    begin
                        pend_reg[0].event_kind <= EV_GRANT;
                        state_reg              <= S_EMIT;
                    end
                    else if (st_rd == ST_HUNGRY)
                    begin
                        pend_reg[0].event_kind <= EV_WAIT;
                        state_reg              <= S_EMIT;
                    end
                    else if (!budget_ok)
                    begin
                        pend_reg[0].event_kind <= EV_REFUSE;
                        state_reg              <= S_EMIT;
                    end
                    else
                    begin
                        portions_used_reg <= portions_used_reg + 16'd1;
                        state_reg         <= S_T_X;
                    end
                end
                S_T_X:
                begin
                    state_reg <= S_T_L;
                end
                S_T_L:
                begin
                    h_reg     <= (st_rd == ST_HUNGRY);
                    state_reg <= S_T_R;
                end
                S_T_R:
                begin
                    lok_reg   <= (st_rd != ST_EAT);
                    state_reg <= S_T_D;
                end
                S_T_D:
                begin
                    if (mode_reg == MODE_REQUEST)
                    begin
                        pend_reg[0].event_kind <= grant ? EV_GRANT : EV_WAIT;
                        state_reg              <= S_EMIT;
                    end
                    else if (!phase_reg)
                    begin
                        // left tested, now the right neighbor
                        gl_reg    <= grant;
                        phase_reg <= 1'b1;
                        tgt_reg   <= right_reg;
                        state_reg <= S_T_X;
                    end
                    else
                    begin
                        priority if (gl_reg && grant)
                        begin
                            pend_reg[0]  <= '{event_kind: EV_GRANT,
                                               target_seat: 5'(left_reg), last: 1'b0};
                            pend_reg[1]  <= '{event_kind: EV_GRANT,
                                               target_seat: 5'(right_reg), last: 1'b1};
                            pend_cnt_reg <= 1'b1;
                        end
                        else if (gl_reg)
                        begin
                            pend_reg[0] <= '{event_kind: EV_GRANT,
                                              target_seat: 5'(left_reg), last: 1'b1};
                        end
                        else if (grant)
                        begin
                            pend_reg[0] <= '{event_kind: EV_GRANT,
                                              target_seat: 5'(right_reg), last: 1'b1};
                        end
                        else
                        begin
                            pend_reg[0] <= '{event_kind: EV_ACK,
                                              target_seat: seat_reg, last: 1'b1};
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        if (pend_idx_reg == pend_cnt_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pend_idx_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // checks on the sequencer
    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("seat ram read and written in the same cycle");

    a_eat_only_hungry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_D && ram_we) |-> (h_reg && lok_reg))
        else $error("seat granted without a hungry seat and free left side");

    a_portion_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (portions_used_reg == $past(portions_used_reg) ||
                  portions_used_reg == $past(portions_used_reg) + 16'd1))
        else $error("portion count moved by more than one");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("input accepted without starting work");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> rsp_valid_reg)
        else $error("result load lost");

endmodule
